FILE: sv/oat_pkg.sv
// Shared types and constants for the ordered array table.
`timescale 1ns / 1ps
`default_nettype none

package oat_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int REQ_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_OVERWRITE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  localparam logic [CNT_W-1:0] FOUND_NONE = 7'h7F;
  localparam logic [CNT_W-1:0] CAP_RESET  = 7'd64;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              ovw;
    logic              rd;
    logic              srch;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  count;
  } cell_cmd_t;

  // Probe token that walks the row one cell per cycle.
  typedef struct packed {
    logic              act;
    logic              hit;
    logic [CNT_W-1:0]  at;
    logic [DATA_W-1:0] data;
  } probe_t;

endpackage

`default_nettype wire

FILE: sv/oat_cell.sv
// One list entry with its shift, write and probe logic.
`timescale 1ns / 1ps
`default_nettype none

module oat_cell
  import oat_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CMP_W = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  cell_cmd_t         cmd,
  input  wire  [DATA_W-1:0] left_entry,
  input  wire  [DATA_W-1:0] right_entry,
  input  probe_t            probe_in,
  output logic [DATA_W-1:0] entry,
  output probe_t            probe_out
);

  localparam logic [CMP_W-1:0] K   = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] KP1 = CMP_W'(IDX + 1);

  logic [DATA_W-1:0] entry_r;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              below;

  assign pos_x = CMP_W'(cmd.pos);
  assign cnt_x = CMP_W'(cmd.count);
  assign below = K < cnt_x;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (K == pos_x) begin
        entry_r <= cmd.val;
      end else if (K > pos_x && K <= cnt_x) begin
        entry_r <= left_entry;
      end
    end else if (cmd.del) begin
      if (K >= pos_x && KP1 < cnt_x) begin
        entry_r <= right_entry;
      end
    end else if (cmd.ovw && K == pos_x) begin
      entry_r <= cmd.val;
    end
  end

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.act) begin
      if (cmd.srch && !probe_in.hit && below && entry_r == cmd.val) begin
        probe_nxt.hit = 1'b1;
        probe_nxt.at  = CNT_W'(IDX);
      end
      if (cmd.rd && K == pos_x) begin
        probe_nxt.data = entry_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.act <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign entry     = entry_r;
  assign probe_out = probe_r;

endmodule

`default_nettype wire

FILE: sv/ordered_array_table_unit.sv
// Ordered array table: a row of entry cells with a request sequencer.
// Usage:
//   Input channel (in_valid/in_stall) carries one request per transaction:
//   append, insert, delete, overwrite, read or search. Each request yields
//   exactly one result transaction on the out_ channel, in order.
//   Config channel (cfg_valid/cfg_ready) writes the capacity in use; write
//   it only while the block is idle. cfg_ready is always high.
// Request flow:
//   Append, insert, delete, overwrite, failed reads and unused codes go
//   through the execute and done states to the output register. Insert
//   and delete move each affected entry one cell at once, in execute.
//   Successful reads and all searches send a probe down the row of DEPTH
//   cells, one cell per cycle, during the walk state. One request is in
//   work at a time; the next is accepted when the sequencer is back at
//   idle.
// Reset: list empty, capacity 64, no result pending. Entry storage is not
//   cleared; only entries below the count are ever read.
// Stall: a finished result waits in the output register; the block still
//   accepts and runs the next request, and holds its result back until
//   the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_table_unit
  import oat_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  [REQ_W-1:0]         in_req_type,
  input  wire  [POS_W-1:0]         in_position,
  input  wire  signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic [ST_W-1:0]          out_status,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic signed [CNT_W-1:0]  out_found_position,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_full,
  output logic                     out_is_empty,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CNT_W-1:0]         cfg_capacity_in_use
);

  localparam int CMP_W = (($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W) + 1;
  localparam logic [CMP_W-1:0] DEPTH_X = CMP_W'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [REQ_W-1:0]  req_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic [DATA_W-1:0] res_rd_r, res_rd_nxt;
  logic [CNT_W-1:0]  res_fd_r, res_fd_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_st_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [CNT_W-1:0]  out_fd_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_full_r;
  logic              out_empty_r;

  logic              in_acc;
  logic              out_free;
  logic              full;
  logic              pos_in;      // position below count
  logic              pos_ins_ok;  // position at or below count
  logic              walk_go;
  logic              is_exec;

  cell_cmd_t         cmd;
  probe_t            inject;
  probe_t            probe_q [DEPTH];
  logic [DATA_W-1:0] ent     [DEPTH];
  probe_t            probe_end;

  // Effective capacity: zero acts as one, above DEPTH acts as DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CMP_W'(cap_r) > DEPTH_X) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign full       = count_r >= cap_eff;
  assign pos_in     = {1'b0, pos_r} < count_r;
  assign pos_ins_ok = {1'b0, pos_r} <= count_r;
  assign is_exec    = state_r == S_EXEC;
  assign walk_go    = (req_r == REQ_SEARCH) || (req_r == REQ_READ && pos_in);

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign probe_end = probe_q[DEPTH-1];

  always_comb begin
    cmd       = '0;
    cmd.rd    = req_r == REQ_READ;
    cmd.srch  = req_r == REQ_SEARCH;
    cmd.val   = val_r;
    cmd.count = count_r;
    cmd.pos   = (req_r == REQ_APPEND) ? count_r : {1'b0, pos_r};
    cmd.ins   = is_exec && !full &&
                (req_r == REQ_APPEND || (req_r == REQ_INSERT && pos_ins_ok));
    cmd.del   = is_exec && req_r == REQ_DELETE && pos_in;
    cmd.ovw   = is_exec && req_r == REQ_OVERWRITE && pos_in;
  end

  always_comb begin
    inject     = '0;
    inject.act = is_exec && walk_go;
  end

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_W-1:0] left_e;
      logic [DATA_W-1:0] right_e;
      probe_t            p_in;
      if (k == 0) begin : g_first
        assign left_e = '0;
        assign p_in   = inject;
      end else begin : g_mid
        assign left_e = ent[k-1];
        assign p_in   = probe_q[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = ent[k+1];
      end
      oat_cell #(
        .IDX   (k),
        .CMP_W (CMP_W)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_entry  (left_e),
        .right_entry (right_e),
        .probe_in    (p_in),
        .entry       (ent[k]),
        .probe_out   (probe_q[k])
      );
    end
  endgenerate

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    res_st_nxt = res_st_r;
    res_rd_nxt = res_rd_r;
    res_fd_nxt = res_fd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_st_nxt = ST_OK;
        res_rd_nxt = '0;
        res_fd_nxt = FOUND_NONE;
        state_nxt  = S_DONE;
        case (req_r) inside
          REQ_APPEND, REQ_INSERT: begin
            if (full) begin
              res_st_nxt = ST_FULL;
            end else if (req_r == REQ_INSERT && !pos_ins_ok) begin
              res_st_nxt = ST_RANGE;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          REQ_DELETE: begin
            if (!pos_in) begin
              res_st_nxt = ST_RANGE;
            end else begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          REQ_OVERWRITE: begin
            if (!pos_in) begin
              res_st_nxt = ST_RANGE;
            end
          end
          REQ_READ: begin
            if (!pos_in) begin
              res_st_nxt = ST_RANGE;
            end else begin
              state_nxt = S_WALK;
            end
          end
          REQ_SEARCH: begin
            state_nxt = S_WALK;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (probe_end.act) begin
          state_nxt = S_DONE;
          if (req_r == REQ_READ) begin
            res_rd_nxt = probe_end.data;
          end else if (probe_end.hit) begin
            res_fd_nxt = probe_end.at;
          end else begin
            res_st_nxt = ST_MISS;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_st_r <= res_st_nxt;
    res_rd_r <= res_rd_nxt;
    res_fd_r <= res_fd_nxt;
    if (in_acc) begin
      req_r <= in_req_type;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (state_r == S_DONE && out_free) begin
      out_st_r    <= res_st_r;
      out_rd_r    <= res_rd_r;
      out_fd_r    <= res_fd_r;
      out_cnt_r   <= count_r;
      out_full_r  <= full;
      out_empty_r <= count_r == '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_fd_r;
  assign out_entry_count    = out_cnt_r;
  assign out_is_full        = out_full_r;
  assign out_is_empty       = out_empty_r;

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= DEPTH_X)
    else $error("entry count exceeds storage depth");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> (count_r == $past(count_r)))
    else $error("entry count changed outside execute step");

  a_probe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    probe_end.act |-> (state_r == S_WALK))
    else $error("probe left the row outside a walk");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_position != FOUND_NONE) |-> (out_status == ST_OK))
    else $error("found position reported with non-ok status");

endmodule

`default_nettype wire
